### rtl/dba_pkg.sv
// ----------------------------------------------------------------------------
// dba_pkg
// Shared types and operation codes for the decimal BCD integer ALU.
// ----------------------------------------------------------------------------
package dba_pkg;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture operands, clear result and counters
      logic add;        // result = a + b
      logic sub;        // result = a - b, ten's complement wrap
      logic mul_add;    // accumulator += shifted a
      logic mul_next;   // move on to the next multiplier digit
      logic mul_done;   // result = accumulator
      logic div_shift;  // bring the next dividend digit into the remainder
      logic div_sub;    // remainder -= b, quotient digit + 1
      logic div_next;   // shift the quotient digit into the result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic b_zero;
      logic a_less;
      logic rep_match;  // repeat count has reached the multiplier digit
      logic last_digit;
      logic try_ok;     // a further trial subtraction fits
   } status_type;

endpackage

### rtl/dba_datapath.sv
// ----------------------------------------------------------------------------
// dba_datapath
// Operand, accumulator and result registers with a full-width BCD adder.
// ----------------------------------------------------------------------------
module dba_datapath #(
   parameter int DIGIT_COUNT = 30
) (
   input  logic                 clock,
   input  dba_pkg::cmd_type     cmd,
   output dba_pkg::status_type  status,
   input  logic [59:0]          operand_a_high,
   input  logic [59:0]          operand_a_low,
   input  logic [59:0]          operand_b_high,
   input  logic [59:0]          operand_b_low,
   output logic [59:0]          result_high,
   output logic [59:0]          result_low,
   output logic                 a_less_than_b,
   output logic                 a_equal_b
);
   import dba_pkg::*;

   localparam int W  = 4 * DIGIT_COUNT;
   localparam int XW = W + 4;
   localparam int CW = $clog2(DIGIT_COUNT);
   localparam logic [XW-1:0] SIXES = {(DIGIT_COUNT + 1){4'h6}};

   // Decimal add over DIGIT_COUNT+1 digits: bias every digit by six, add, and
   // take the six back out of each digit that produced no carry.
   function automatic logic [XW-1:0] bcd_add(input logic [XW-1:0] x,
                                             input logic [XW-1:0] y,
                                             input logic          cin);
      logic [XW:0]   t1;
      logic [XW:0]   t2;
      logic [XW:0]   cv;
      logic [XW-1:0] fix;
      t1 = {1'b0, x} + {1'b0, SIXES};
      t2 = t1 + {1'b0, y} + {{XW{1'b0}}, cin};
      cv = t1 ^ {1'b0, y} ^ t2;
      for (int k = 0; k <= DIGIT_COUNT; k++) begin
         fix[4*k +: 4] = cv[4*k + 4] ? 4'd0 : 4'd6;
      end
      return t2[XW-1:0] - fix;
   endfunction

   function automatic logic [XW-1:0] nines(input logic [XW-1:0] x);
      logic [XW-1:0] r;
      for (int k = 0; k <= DIGIT_COUNT; k++) begin
         r[4*k +: 4] = 4'd9 - x[4*k +: 4];
      end
      return r;
   endfunction

   logic [W-1:0]  a_in_c, b_in_c;
   logic [W-1:0]  a_ff, b_ff, res_ff;
   logic [XW-1:0] acc_ff;
   logic [3:0]    rep_ff;
   logic [CW-1:0] idx_ff;
   logic          lt_ff, eq_ff;
   logic [XW-1:0] b_ext, mul_sum, div_diff;

   // Unpack and clamp the incoming digits; digits past DIGIT_COUNT are dropped.
   always_comb begin
      logic [3:0] na, nb;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (i < 15) begin
            na = operand_a_low[4*i +: 4];
            nb = operand_b_low[4*i +: 4];
         end else begin
            na = operand_a_high[4*(i-15) +: 4];
            nb = operand_b_high[4*(i-15) +: 4];
         end
         a_in_c[4*i +: 4] = (na > 4'd9) ? 4'd9 : na;
         b_in_c[4*i +: 4] = (nb > 4'd9) ? 4'd9 : nb;
      end
   end

   assign b_ext    = {4'd0, b_ff};
   assign mul_sum  = bcd_add(acc_ff, {4'd0, a_ff}, 1'b0);
   assign div_diff = bcd_add(acc_ff, nines(b_ext), 1'b1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff   <= a_in_c;
         b_ff   <= b_in_c;
         res_ff <= '0;
         acc_ff <= '0;
         rep_ff <= '0;
         idx_ff <= '0;
         lt_ff  <= a_in_c < b_in_c;
         eq_ff  <= a_in_c == b_in_c;
      end
      if (cmd.add) begin
         res_ff <= W'(bcd_add({4'd0, a_ff}, b_ext, 1'b0));
      end
      if (cmd.sub) begin
         res_ff <= W'(bcd_add({4'd0, a_ff}, nines(b_ext), 1'b1));
      end
      if (cmd.mul_add) begin
         acc_ff <= {4'd0, mul_sum[W-1:0]};
         rep_ff <= rep_ff + 4'd1;
      end
      if (cmd.mul_next) begin
         a_ff   <= a_ff << 4;
         b_ff   <= b_ff >> 4;
         rep_ff <= '0;
         idx_ff <= idx_ff + CW'(1);
      end
      if (cmd.mul_done) begin
         res_ff <= acc_ff[W-1:0];
      end
      if (cmd.div_shift) begin
         acc_ff <= {acc_ff[XW-5:0], a_ff[W-1 -: 4]};
         a_ff   <= a_ff << 4;
         rep_ff <= '0;
      end
      if (cmd.div_sub) begin
         acc_ff <= div_diff;
         rep_ff <= rep_ff + 4'd1;
      end
      if (cmd.div_next) begin
         res_ff <= {res_ff[W-5:0], rep_ff};
         idx_ff <= idx_ff + CW'(1);
      end
   end

   assign status.b_zero     = (b_ff == '0);
   assign status.a_less     = lt_ff;
   assign status.rep_match  = (rep_ff == b_ff[3:0]);
   assign status.last_digit = (idx_ff == CW'(DIGIT_COUNT - 1));
   assign status.try_ok     = (rep_ff != 4'd9) && (acc_ff >= b_ext);

   // Repack the result; positions past DIGIT_COUNT read as zero.
   always_comb begin
      result_high = '0;
      result_low  = '0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (i < 15) begin
            result_low[4*i +: 4] = res_ff[4*i +: 4];
         end else begin
            result_high[4*(i-15) +: 4] = res_ff[4*i +: 4];
         end
      end
   end

   assign a_less_than_b = lt_ff;
   assign a_equal_b     = eq_ff;

endmodule

### rtl/dba_ctrl.sv
// ----------------------------------------------------------------------------
// dba_ctrl
// Sequencer for the BCD ALU: handshakes and per-operation step control.
// ----------------------------------------------------------------------------
module dba_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2:0]          req_op,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output dba_pkg::cmd_type    cmd,
   input  dba_pkg::status_type status
);
   import dba_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_DSHIFT = 3'd3;
   localparam logic [2:0] S_DTRY   = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               op_in    = req_op;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            priority if (op_ff == OP_ADD) begin
               cmd.add = 1'b1;
            end else if (op_ff == OP_SUB) begin
               cmd.sub = 1'b1;
            end else if (op_ff == OP_MUL) begin
               state_in = S_MUL;
            end else if (op_ff == OP_DIV) begin
               if (!status.b_zero && !status.a_less) begin
                  state_in = S_DSHIFT;
               end
            end else begin
               // Compare only and the unused codes: the cleared result stands.
               state_in = S_DONE;
            end
         end
         S_MUL: begin
            priority if (!status.rep_match) begin
               cmd.mul_add = 1'b1;
            end else if (status.last_digit) begin
               cmd.mul_done = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.mul_next = 1'b1;
            end
         end
         S_DSHIFT: begin
            cmd.div_shift = 1'b1;
            state_in      = S_DTRY;
         end
         S_DTRY: begin
            if (status.try_ok) begin
               cmd.div_sub = 1'b1;
            end else begin
               cmd.div_next = 1'b1;
               state_in     = status.last_digit ? S_DONE : S_DSHIFT;
            end
         end
         S_DONE: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_ADD;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_DONE);

endmodule

### rtl/decimal_bcd_integer_alu.sv
// ----------------------------------------------------------------------------
// decimal_bcd_integer_alu
// Unsigned packed-BCD add, subtract, multiply, divide and compare.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns one result item for it.
// Add and subtract compute the result in one execute step; compare keeps the
// cleared result. Multiply runs one digit of b per pass and adds a into the
// accumulator once per unit of that digit. Divide produces one quotient digit
// per pass, each pass being one shift step, up to nine trial subtractions and
// one step to store the digit; a zero divisor or a dividend below the divisor
// goes straight to the result. The datapath does one decimal addition per
// cycle while a sequence runs. A stalled result holds the block for as long
// as it waits. A new item is accepted once the previous result has been
// taken. Nibbles above nine are treated as nine, and both compare flags are
// valid for every operation.
module decimal_bcd_integer_alu #(
   parameter int DIGIT_COUNT = 30
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operand_a_high [59:0], operand_a_low [119:60],
   // operand_b_high [179:120], operand_b_low [239:180]
   input  logic [239:0] req_tdata,
   // operation [2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_high [59:0], result_low [119:60], a_less_than_b [120],
   // a_equal_b [121], zero padding [127:122]
   output logic [127:0] rsp_tdata
);
   import dba_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [59:0] result_high, result_low;
   logic        a_less_than_b, a_equal_b;

   dba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   dba_datapath #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .operand_a_high (req_tdata[59:0]),
      .operand_a_low  (req_tdata[119:60]),
      .operand_b_high (req_tdata[179:120]),
      .operand_b_low  (req_tdata[239:180]),
      .result_high    (result_high),
      .result_low     (result_low),
      .a_less_than_b  (a_less_than_b),
      .a_equal_b      (a_equal_b)
   );

   assign rsp_tdata = {6'd0, a_equal_b, a_less_than_b, result_low, result_high};

`ifndef ASSERT_OFF
   // The two compare flags exclude each other.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(a_less_than_b && a_equal_b))
      else $error("compare flags both set");

   // Once an item is taken the block is busy until its result is delivered.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while busy");

   // A delivered result is not presented a second time.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> !rsp_tvalid)
      else $error("result repeated");

   // Input and output sides are never active together.
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("ready while a result is pending");
`endif

endmodule

### dv/decimal_bcd_integer_alu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_bcd_integer_alu_checker
// Watches both streams of the decimal ALU, predicts each result item from
// the accepted request item and compares the two field by field.
// ----------------------------------------------------------------------------
module decimal_bcd_integer_alu_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [239:0] req_tdata,
   input  logic [2:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   output int           fail_count,
   output int           pending_count
);
   import dba_pkg::*;

   localparam int NDIG = 30;

   typedef struct packed {
      logic          equal;
      logic          less;
      logic [59:0]   low;
      logic [59:0]   high;
   } bcd_result_type;

   typedef int digit_array_type [NDIG];

   bcd_result_type expected_results [$];

   function automatic digit_array_type to_digits(logic [59:0] hi, logic [59:0] lo);
      digit_array_type d;
      int v;
      for (int i = 0; i < NDIG; i++) begin
         v = (i < 15) ? lo[(i % 15) * 4 +: 4] : hi[(i % 15) * 4 +: 4];
         d[i] = (v > 9) ? 9 : v;
      end
      return d;
   endfunction

   // Digits are least significant first; returns -1, 0 or 1.
   function automatic int compare_digits(int x[], int y[], int n);
      for (int i = n - 1; i >= 0; i--)
         if (x[i] != y[i]) return (x[i] < y[i]) ? -1 : 1;
      return 0;
   endfunction

   function automatic bcd_result_type compute_bcd(logic [2:0] op, logic [239:0] data);
      digit_array_type a, b, r;
      int ra[], ya[], xa[];
      int c, carry, s, col, qd, borrow;
      bit b_zero;
      bcd_result_type res;
      a = to_digits(data[59:0], data[119:60]);
      b = to_digits(data[179:120], data[239:180]);
      xa = new[NDIG];
      ya = new[NDIG];
      foreach (a[i]) begin
         xa[i] = a[i];
         ya[i] = b[i];
         r[i] = 0;
      end
      c = compare_digits(xa, ya, NDIG);
      b_zero = 1;
      foreach (b[i]) if (b[i] != 0) b_zero = 0;
      case (op)
         OP_ADD: begin
            carry = 0;
            for (int i = 0; i < NDIG; i++) begin
               s = a[i] + b[i] + carry;
               r[i] = s % 10;
               carry = s / 10;
            end
         end
         OP_SUB: begin
            borrow = 0;
            for (int i = 0; i < NDIG; i++) begin
               s = b[i] + borrow;
               if (a[i] < s) begin
                  r[i] = a[i] + 10 - s;
                  borrow = 1;
               end else begin
                  r[i] = a[i] - s;
                  borrow = 0;
               end
            end
         end
         OP_MUL: begin
            carry = 0;
            for (int k = 0; k < NDIG; k++) begin
               col = carry;
               for (int i = 0; i <= k; i++) col += a[i] * b[k - i];
               r[k] = col % 10;
               carry = col / 10;
            end
         end
         OP_DIV: begin
            if (!b_zero && c >= 0) begin
               // Long division with a remainder one digit wider than the operands.
               ra = new[NDIG + 1];
               ya = new[NDIG + 1];
               foreach (ra[j]) ra[j] = 0;
               for (int j = 0; j < NDIG; j++) ya[j] = b[j];
               ya[NDIG] = 0;
               for (int i = NDIG - 1; i >= 0; i--) begin
                  qd = 0;
                  for (int j = NDIG; j > 0; j--) ra[j] = ra[j - 1];
                  ra[0] = a[i];
                  while (qd < 9 && compare_digits(ra, ya, NDIG + 1) >= 0) begin
                     borrow = 0;
                     for (int j = 0; j <= NDIG; j++) begin
                        s = ya[j] + borrow;
                        if (ra[j] < s) begin
                           ra[j] = ra[j] + 10 - s;
                           borrow = 1;
                        end else begin
                           ra[j] = ra[j] - s;
                           borrow = 0;
                        end
                     end
                     qd++;
                  end
                  r[i] = qd;
               end
            end
         end
         default: ;
      endcase
      res = '0;
      for (int i = 0; i < NDIG; i++)
         if (i < 15) res.low[(i % 15) * 4 +: 4] = r[i][3:0];
         else res.high[(i % 15) * 4 +: 4] = r[i][3:0];
      res.less = (c < 0);
      res.equal = (c == 0);
      return res;
   endfunction

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      bcd_result_type want;
      bcd_result_type got;
      if (reset) begin
         fail_count <= 0;
         expected_results.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(compute_bcd(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[121:0];
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result item, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (got.high !== want.high || got.low !== want.low ||
                   got.less !== want.less || got.equal !== want.equal ||
                   rsp_tdata[127:122] !== 6'd0) begin
                  $display("%0t: result mismatch, expected %h_%h lt=%b eq=%b, actual %h_%h lt=%b eq=%b",
                           $time, want.high, want.low, want.less, want.equal,
                           got.high, got.low, got.less, got.equal);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### dv/decimal_bcd_integer_alu_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_bcd_integer_alu_test
// Drives directed and random BCD operations into the ALU and gives the verdict.
// ----------------------------------------------------------------------------
// The stimulus side only: a separate checker predicts and compares every
// result item. The sender works in bursts with random gaps, and the receiver
// stalls on a pattern of its own, so that pauses land on every phase of the
// long multiply and divide sequences.
module decimal_bcd_integer_alu_test;
   import dba_pkg::*;

   localparam logic [2:0] OP_CMP = 3'd4;
   localparam int RANDOM_ITEMS = 450;
   localparam int CYCLE_LIMIT = 1500000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [239:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   int           fail_count;
   int           pending_count;
   int           cycle_count = 0;

   always #5 clock = ~clock;

   decimal_bcd_integer_alu u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   decimal_bcd_integer_alu_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // The timeout covers the slowest correct run many times over.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // The receiver picks its ready afresh every clock: mostly ready, often a random
   // value, and now and then stalled.
   always @(posedge clock) begin
      int mode;
      mode = $urandom_range(0, 99);
      if (mode < 50) rsp_tready <= 1'b1;
      else if (mode < 90) rsp_tready <= $urandom_range(0, 1);
      else rsp_tready <= 1'b0;
   end

   // A random operand of fifteen digits per half. Mostly valid digits, with the
   // odd nibble above nine, and a random number of leading zero digits so that
   // small values are common too.
   function automatic logic [59:0] random_half(int dirty_pct, int top_digit);
      logic [59:0] h;
      h = '0;
      for (int i = 0; i < 15; i++)
         if (i < top_digit)
            h[i * 4 +: 4] = ($urandom_range(0, 99) < dirty_pct) ?
                            4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      return h;
   endfunction

   function automatic logic [119:0] random_operand(int dirty_pct);
      int n;
      n = $urandom_range(0, 30);
      if ($urandom_range(0, 3) == 0) n = 30;
      return {random_half(dirty_pct, (n > 15) ? n - 15 : 0),
              random_half(dirty_pct, (n > 15) ? 15 : n)};
   endfunction

   // Operands are given as {high, low}; tdata takes a_high, a_low, b_high, b_low.
   task automatic send_item(logic [2:0] op, logic [119:0] a, logic [119:0] b);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {b[59:0], b[119:60], a[59:0], a[119:60]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic idle_cycles(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   logic [119:0] all_nines;
   logic [119:0] all_fs;
   logic [119:0] one;
   logic [119:0] op_a, op_b;
   logic [2:0]   op;
   int           burst;

   initial begin
      all_nines = {30{4'h9}};
      all_fs    = '1;
      one       = 120'd1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items: field extremes, every operation, overflow wrap,
      // ten's complement wrap, division by zero, divide with a below b, nibbles
      // above nine and the unused operation codes.
      send_item(OP_ADD, '0, '0);
      send_item(OP_ADD, all_nines, one);
      send_item(OP_ADD, all_fs, all_fs);
      send_item(OP_SUB, '0, one);
      send_item(OP_SUB, all_nines, all_nines);
      send_item(OP_SUB, one, all_fs);
      send_item(OP_MUL, all_nines, all_nines);
      send_item(OP_MUL, all_fs, one);
      send_item(OP_MUL, '0, all_nines);
      send_item(OP_DIV, all_nines, '0);
      send_item(OP_DIV, one, all_nines);
      send_item(OP_DIV, all_nines, one);
      send_item(OP_DIV, all_fs, 120'h7);
      send_item(OP_DIV, all_nines, all_nines);
      send_item(OP_CMP, all_nines, all_fs);
      send_item(OP_CMP, one, '0);
      send_item(3'd5, '0, one);
      send_item(3'd6, all_fs, all_fs);
      send_item(3'd7, 120'h5a, 120'h59);
      idle_cycles(1);

      // The sender holds off here until every result has come back.
      while (pending_count != 0) @(posedge clock);

      for (int k = 0; k < RANDOM_ITEMS; k += burst) begin
         burst = $urandom_range(1, 8);
         for (int j = 0; j < burst; j++) begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(4, 7))
                                              : 3'($urandom_range(0, 3));
            op_a = random_operand(5);
            op_b = ($urandom_range(0, 9) == 0) ? op_a : random_operand(5);
            if ($urandom_range(0, 15) == 0) op_b = '0;
            send_item(op, op_a, op_b);
         end
         if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 20));
      end
      idle_cycles(1);

      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
